FILE: sv/assert_macros.svh
// Assertion macros used by the RTL of the color converter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check that is switched off while reset is asserted (active low).
`define ASSERT_CLKD(name, ck, rn, prop, msg) \
    name: assert property (@(posedge ck) disable iff (!rn) prop) else $error(msg);

// Clocked check that also holds while reset is asserted.
`define ASSERT_ALWAYS(name, ck, prop, msg) \
    name: assert property (@(posedge ck) prop) else $error(msg);

`endif

FILE: sv/hsl2rgb_pkg.sv
// Types and fixed constants of the HSL to RGB converter.
`default_nettype none

package hsl2rgb_pkg;

    // Width of one color channel and of the alpha byte.
    localparam int CHAN_W  = 8;
    localparam int ALPHA_W = 8;

    // Largest channel value; results above it saturate.
    localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;

    // Packed width of the result word: red, green, blue, alpha.
    localparam int OUT_TDATA_W = 3 * CHAN_W + ALPHA_W;

    // Hue sector, the integer part of six times the hue.
    typedef enum logic [2:0] {
        SECT_RED_YELLOW    = 3'd0,
        SECT_YELLOW_GREEN  = 3'd1,
        SECT_GREEN_CYAN    = 3'd2,
        SECT_CYAN_BLUE     = 3'd3,
        SECT_BLUE_MAGENTA  = 3'd4,
        SECT_MAGENTA_RED   = 3'd5
    } sector_t;

endpackage

`default_nettype wire

FILE: sv/hsl_to_rgb_converter.sv
// HSL to RGB pixel converter: a five-stage pipeline with stream handshakes.
//
// Usage:
//   Slave side (s_axis_*): one pixel per word with hue, saturation and lightness as
//   unsigned fractions with FRAC_BITS fraction bits (2^FRAC_BITS means 1.0) and an
//   alpha byte. Values above 1.0 are taken as 1.0.
//   Master side (m_axis_*): one word per pixel with 8-bit red, green, blue, rounded
//   half up and saturated at 255, and the unchanged alpha byte.
//   Throughput: one pixel per clock cycle, sustained, as long as the receiver takes
//   a word each cycle.
//   Depth: five register stages; an accepted word passes through stages one to five
//   in order and is offered on the master side from the stage five register.
//   Two multiplies set the depth: the chroma product in stage two and the
//   intermediate-value product in stage three; the 255 scaling sits in stage five.
//   Stall: each stage holds its word while the stage after it is full and stalled,
//   and empty stages keep filling, so nothing is dropped or repeated. s_axis_tready
//   is low only when all five stages are full and the receiver stalls.
//   Reset: all stages come up empty; the block takes words from the first cycle on.
`default_nettype none

`include "assert_macros.svh"

module hsl_to_rgb_converter #(
    parameter int FRAC_BITS = 16,
    localparam int FLD_W = FRAC_BITS + 1,
    localparam int IN_BITS = 3 * FLD_W + hsl2rgb_pkg::ALPHA_W,
    localparam int IN_TDATA_W = ((IN_BITS + 7) / 8) * 8
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // Fields from bit 0 up: hue, saturation, lightness, alpha_in, zero fill.
    input  wire logic [IN_TDATA_W-1:0]              s_axis_tdata,
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // Fields from bit 0 up: red, green, blue, alpha_out.
    output logic [hsl2rgb_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);

    localparam int F       = FRAC_BITS;
    localparam int PROD_W  = 2 * FLD_W;
    localparam int HP_W    = F + 3;
    localparam int V_W     = F + 3;
    localparam int SCL_W   = V_W + hsl2rgb_pkg::CHAN_W;
    localparam int NSTG    = 5;

    localparam logic [FLD_W-1:0]  FIX_ONE   = FLD_W'(1) << F;
    localparam logic [FLD_W:0]    FIX_ONE_W = (FLD_W + 1)'(1) << F;
    localparam logic [PROD_W-1:0] PROD_HALF = PROD_W'(1) << (F - 1);
    localparam logic [SCL_W-1:0]  SCL_ONE   = SCL_W'(1) << F;
    localparam logic [2:0]        SECT_LAST = 3'(hsl2rgb_pkg::SECT_MAGENTA_RED);

    // Stage valid bits and per-stage load enables.
    logic [NSTG:1] vld_reg;
    logic [NSTG:1] stage_en;

    assign stage_en[5] = !vld_reg[5] || m_axis_tready;
    assign stage_en[4] = !vld_reg[4] || stage_en[5];
    assign stage_en[3] = !vld_reg[3] || stage_en[4];
    assign stage_en[2] = !vld_reg[2] || stage_en[3];
    assign stage_en[1] = !vld_reg[1] || stage_en[2];

    assign s_axis_tready = stage_en[1];
    assign m_axis_tvalid = vld_reg[5];

    // Valid bits advance with their stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (stage_en[1])
            begin
                vld_reg[1] <= s_axis_tvalid;
            end
            for (int k = 2; k <= NSTG; k++)
            begin
                if (stage_en[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    // Stage 1: saturate the inputs, form 1 - |2L - 1|, the sector and 1 - |H' mod 2 - 1|.
    logic [FLD_W-1:0]  hue_in;
    logic [FLD_W-1:0]  sat_in;
    logic [FLD_W-1:0]  light_in;
    logic [FLD_W-1:0]  hue_c;
    logic [FLD_W-1:0]  sat_c;
    logic [FLD_W-1:0]  light_c;
    logic [FLD_W:0]    two_l;
    logic [FLD_W:0]    t_abs;
    logic [HP_W-1:0]   hue3;
    logic [HP_W-1:0]   hp;
    logic [FLD_W-1:0]  frac2;
    logic [FLD_W-1:0]  d_abs;
    logic [2:0]        sect_raw;

    logic [FLD_W-1:0]          omt_next;
    logic [FLD_W-1:0]          omd_next;
    hsl2rgb_pkg::sector_t      sect_next;

    logic [FLD_W-1:0]                   s1_omt_reg;
    logic [FLD_W-1:0]                   s1_sat_reg;
    logic [FLD_W-1:0]                   s1_light_reg;
    logic [FLD_W-1:0]                   s1_omd_reg;
    hsl2rgb_pkg::sector_t               s1_sect_reg;
    logic [hsl2rgb_pkg::ALPHA_W-1:0]    s1_alpha_reg;

    always_comb
    begin
        hue_in   = s_axis_tdata[FLD_W-1:0];
        sat_in   = s_axis_tdata[2*FLD_W-1:FLD_W];
        light_in = s_axis_tdata[3*FLD_W-1:2*FLD_W];
        hue_c    = (hue_in > FIX_ONE) ? FIX_ONE : hue_in;
        sat_c    = (sat_in > FIX_ONE) ? FIX_ONE : sat_in;
        light_c  = (light_in > FIX_ONE) ? FIX_ONE : light_in;

        two_l    = {light_c, 1'b0};
        t_abs    = (two_l >= FIX_ONE_W) ? (two_l - FIX_ONE_W) : (FIX_ONE_W - two_l);
        omt_next = FIX_ONE - t_abs[FLD_W-1:0];

        // Six times the hue as four times plus two times.
        hue3     = HP_W'(hue_c);
        hp       = (hue3 << 2) + (hue3 << 1);
        sect_raw = hp[HP_W-1:F];
        frac2    = hp[F:0];
        d_abs    = (frac2 >= FIX_ONE) ? (frac2 - FIX_ONE) : (FIX_ONE - frac2);
        omd_next = FIX_ONE - d_abs;

        // Full hue lands on sector six and is folded into the last sector.
        if (sect_raw > SECT_LAST)
        begin
            sect_next = hsl2rgb_pkg::SECT_MAGENTA_RED;
        end
        else
        begin
            sect_next = hsl2rgb_pkg::sector_t'(sect_raw);
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[1])
        begin
            s1_omt_reg   <= omt_next;
            s1_sat_reg   <= sat_c;
            s1_light_reg <= light_c;
            s1_omd_reg   <= omd_next;
            s1_sect_reg  <= sect_next;
            s1_alpha_reg <= s_axis_tdata[3*FLD_W+hsl2rgb_pkg::ALPHA_W-1:3*FLD_W];
        end
    end

    // Stage 2: chroma, product rounded half up back to the fraction width.
    logic [PROD_W-1:0] chroma_prod;
    logic [FLD_W-1:0]  chroma_next;

    logic [FLD_W-1:0]                   s2_chroma_reg;
    logic [FLD_W-1:0]                   s2_light_reg;
    logic [FLD_W-1:0]                   s2_omd_reg;
    hsl2rgb_pkg::sector_t               s2_sect_reg;
    logic [hsl2rgb_pkg::ALPHA_W-1:0]    s2_alpha_reg;

    always_comb
    begin
        chroma_prod = PROD_W'(s1_omt_reg) * PROD_W'(s1_sat_reg) + PROD_HALF;
        chroma_next = chroma_prod[F+FLD_W-1:F];
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[2])
        begin
            s2_chroma_reg <= chroma_next;
            s2_light_reg  <= s1_light_reg;
            s2_omd_reg    <= s1_omd_reg;
            s2_sect_reg   <= s1_sect_reg;
            s2_alpha_reg  <= s1_alpha_reg;
        end
    end

    // Stage 3: intermediate value X = C * (1 - |H' mod 2 - 1|), rounded half up.
    logic [PROD_W-1:0] x_prod;
    logic [FLD_W-1:0]  x_next;

    logic [FLD_W-1:0]                   s3_chroma_reg;
    logic [FLD_W-1:0]                   s3_x_reg;
    logic [FLD_W-1:0]                   s3_light_reg;
    hsl2rgb_pkg::sector_t               s3_sect_reg;
    logic [hsl2rgb_pkg::ALPHA_W-1:0]    s3_alpha_reg;

    always_comb
    begin
        x_prod = PROD_W'(s2_chroma_reg) * PROD_W'(s2_omd_reg) + PROD_HALF;
        x_next = x_prod[F+FLD_W-1:F];
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[3])
        begin
            s3_chroma_reg <= s2_chroma_reg;
            s3_x_reg      <= x_next;
            s3_light_reg  <= s2_light_reg;
            s3_sect_reg   <= s2_sect_reg;
            s3_alpha_reg  <= s2_alpha_reg;
        end
    end

    // Stage 4: arrange C, X and 0 by sector and add the offset, in half units.
    logic [FLD_W-1:0] r1;
    logic [FLD_W-1:0] g1;
    logic [FLD_W-1:0] b1;
    logic [V_W-1:0]   red_v_next;
    logic [V_W-1:0]   grn_v_next;
    logic [V_W-1:0]   blu_v_next;

    logic [V_W-1:0]                     s4_red_v_reg;
    logic [V_W-1:0]                     s4_grn_v_reg;
    logic [V_W-1:0]                     s4_blu_v_reg;
    logic [hsl2rgb_pkg::ALPHA_W-1:0]    s4_alpha_reg;

    function automatic logic [V_W-1:0] half_units(
        input logic [FLD_W-1:0] c1,
        input logic [FLD_W-1:0] light,
        input logic [FLD_W-1:0] chroma
    );
        logic [V_W-1:0] pos;
        logic [V_W-1:0] chr;
        pos = V_W'({c1, 1'b0}) + V_W'({light, 1'b0});
        chr = V_W'(chroma);
        return (pos >= chr) ? (pos - chr) : '0;
    endfunction

    always_comb
    begin
        case (s3_sect_reg)
            hsl2rgb_pkg::SECT_RED_YELLOW:
            begin
                r1 = s3_chroma_reg; g1 = s3_x_reg;      b1 = '0;
            end
            hsl2rgb_pkg::SECT_YELLOW_GREEN:
            begin
                r1 = s3_x_reg;      g1 = s3_chroma_reg; b1 = '0;
            end
            hsl2rgb_pkg::SECT_GREEN_CYAN:
            begin
                r1 = '0;            g1 = s3_chroma_reg; b1 = s3_x_reg;
            end
            hsl2rgb_pkg::SECT_CYAN_BLUE:
            begin
                r1 = '0;            g1 = s3_x_reg;      b1 = s3_chroma_reg;
            end
            hsl2rgb_pkg::SECT_BLUE_MAGENTA:
            begin
                r1 = s3_x_reg;      g1 = '0;            b1 = s3_chroma_reg;
            end
            default:
            begin
                r1 = s3_chroma_reg; g1 = '0;            b1 = s3_x_reg;
            end
        endcase
        red_v_next = half_units(r1, s3_light_reg, s3_chroma_reg);
        grn_v_next = half_units(g1, s3_light_reg, s3_chroma_reg);
        blu_v_next = half_units(b1, s3_light_reg, s3_chroma_reg);
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[4])
        begin
            s4_red_v_reg <= red_v_next;
            s4_grn_v_reg <= grn_v_next;
            s4_blu_v_reg <= blu_v_next;
            s4_alpha_reg <= s3_alpha_reg;
        end
    end

    // Stage 5: scale to 8 bits with round-half-up and saturate; this is the output word.
    function automatic logic [hsl2rgb_pkg::CHAN_W-1:0] to_byte(input logic [V_W-1:0] v);
        logic [SCL_W-1:0] scaled;
        logic [SCL_W-1:0] shifted;
        scaled  = SCL_W'(v) * SCL_W'(hsl2rgb_pkg::CHAN_MAX) + SCL_ONE;
        shifted = scaled >> (F + 1);
        return (shifted > SCL_W'(hsl2rgb_pkg::CHAN_MAX)) ? hsl2rgb_pkg::CHAN_MAX
                                                         : shifted[hsl2rgb_pkg::CHAN_W-1:0];
    endfunction

    logic [hsl2rgb_pkg::OUT_TDATA_W-1:0] out_word_next;
    logic [hsl2rgb_pkg::OUT_TDATA_W-1:0] out_word_reg;

    assign out_word_next = {s4_alpha_reg, to_byte(s4_blu_v_reg),
                            to_byte(s4_grn_v_reg), to_byte(s4_red_v_reg)};

    always_ff @(posedge clk)
    begin
        if (stage_en[5])
        begin
            out_word_reg <= out_word_next;
        end
    end

    assign m_axis_tdata = out_word_reg;

    // Checks on the pipeline's own arithmetic and flow control.
    `ASSERT_CLKD(a_chroma_le_one, clk, rst_n,
                 vld_reg[2] |-> (s2_chroma_reg <= FIX_ONE), "chroma above one")
    `ASSERT_CLKD(a_x_le_chroma, clk, rst_n,
                 vld_reg[3] |-> (s3_x_reg <= s3_chroma_reg), "X above chroma")
    `ASSERT_CLKD(a_held_stage, clk, rst_n,
                 (vld_reg[3] && !stage_en[3]) |=> (vld_reg[3] && $stable(s3_x_reg)),
                 "stalled stage changed")
    `ASSERT_ALWAYS(a_ready_when_empty, clk,
                   !vld_reg[5] |-> s_axis_tready, "not ready with empty output")

endmodule

`default_nettype wire
